>>> design/assert_macros.svh
// Assertion macros used by the checker file hskr_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> design/hskr_pkg.sv
package hskr_pkg;

  // Record layout: key in the upper half, tag in the lower half
  localparam int KEY_W = 16;
  localparam int TAG_W = 16;
  localparam int REC_W = KEY_W + TAG_W;

  // Default number of record slots
  localparam int STORE_SIZE_DEF = 64;

endpackage

>>> design/hskr_ram.sv
module hskr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/heap_sort_keyed_records_core.sv
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_stall | in_key, in_tag, in_last
// out     | output    | out_valid/out_stall | out_sorted_key, out_sorted_tag,
//         |           |                   | out_final_res, out_overflow
//
// Loading accepts one record per cycle. After the record marked last the block
// sorts in place by heapsort, one sift-down at a time, reading children through
// the single read port of the record memory. Emission then fetches each record
// only after the previous result has been taken.
// Reset (rst_n low, synchronous) empties the batch; memory contents persist.
// in_stall is high from the last record until the final result is taken;
// out_stall holds the current result in its output register.
module heap_sort_keyed_records_core #(
  parameter int STORE_SIZE = hskr_pkg::STORE_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [hskr_pkg::KEY_W-1:0] in_key,
  input  logic [hskr_pkg::TAG_W-1:0] in_tag,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [hskr_pkg::KEY_W-1:0] out_sorted_key,
  output logic [hskr_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                      out_final_res,
  output logic                      out_overflow
);

  localparam int KEY_W  = hskr_pkg::KEY_W;
  localparam int TAG_W  = hskr_pkg::TAG_W;
  localparam int REC_W  = hskr_pkg::REC_W;
  localparam int IDX_W  = $clog2(STORE_SIZE + 1);
  localparam int CH_W   = IDX_W + 1;
  localparam int ADDR_W = $clog2(STORE_SIZE);

  typedef enum logic [11:0] {
    S_LOAD   = 12'b0000_0000_0001,
    S_B_RD   = 12'b0000_0000_0010,
    S_B_GETV = 12'b0000_0000_0100,
    S_SIFT   = 12'b0000_0000_1000,
    S_RD_R   = 12'b0000_0001_0000,
    S_CMP    = 12'b0000_0010_0000,
    S_X_RDI  = 12'b0000_0100_0000,
    S_X_GETV = 12'b0000_1000_0000,
    S_X_WR   = 12'b0001_0000_0000,
    S_E_RD   = 12'b0010_0000_0000,
    S_E_LD   = 12'b0100_0000_0000,
    S_E_WT   = 12'b1000_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               drop_r, drop_nxt;
  logic               xtr_r, xtr_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   node_r, node_nxt;
  logic [IDX_W-1:0]   size_r, size_nxt;
  logic [REC_W-1:0]   v_r, v_nxt;
  logic [REC_W-1:0]   lrec_r, lrec_nxt;
  logic               has_r_r, has_r_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic               out_final_r, out_final_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [REC_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [REC_W-1:0]   ram_rdata;

  logic               in_xfer;
  logic               out_xfer;
  logic [IDX_W-1:0]   n_w;
  logic [CH_W-1:0]    left_w;
  logic [CH_W-1:0]    right_w;
  logic [CH_W-1:0]    size_x;
  logic [ADDR_W-1:0]  node_addr;
  logic [KEY_W-1:0]   v_key;
  logic [KEY_W-1:0]   l_key;
  logic [KEY_W-1:0]   r_key;
  logic               take_l;
  logic [REC_W-1:0]   best_rec;
  logic [KEY_W-1:0]   best_key;
  logic               take_r;
  logic               sift_done;

  hskr_ram #(
    .WIDTH(REC_W),
    .DEPTH(STORE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Handshakes
  assign in_stall = (state_r != S_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // Heap geometry of the current node (1-based)
  assign left_w    = {node_r, 1'b0};
  assign right_w   = left_w + 1'b1;
  assign size_x    = CH_W'(size_r);
  assign node_addr = ADDR_W'(node_r - 1'b1);

  // Child selection: strict compares, left wins a tie
  assign v_key    = v_r[REC_W-1 -: KEY_W];
  assign l_key    = lrec_r[REC_W-1 -: KEY_W];
  assign r_key    = ram_rdata[REC_W-1 -: KEY_W];
  assign take_l   = (l_key > v_key);
  assign best_rec = take_l ? lrec_r : v_r;
  assign best_key = best_rec[REC_W-1 -: KEY_W];
  assign take_r   = has_r_r && (r_key > best_key);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    xtr_nxt       = xtr_r;
    i_nxt         = i_r;
    node_nxt      = node_r;
    size_nxt      = size_r;
    v_nxt         = v_r;
    lrec_nxt      = lrec_r;
    has_r_nxt     = has_r_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_tag_nxt   = out_tag_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = node_addr;
    ram_wdata     = v_r;
    ram_re        = 1'b0;
    ram_raddr     = node_addr;
    n_w           = cnt_r;
    sift_done     = 1'b0;

    case (state_r)
      // Store records until the last one, drop when full
      S_LOAD: begin
        if (in_xfer) begin
          if (cnt_r < IDX_W'(STORE_SIZE)) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(cnt_r);
            ram_wdata = {in_key, in_tag};
            n_w       = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          cnt_nxt = n_w;
          if (in_last) begin
            if (n_w >= IDX_W'(2)) begin
              size_nxt  = n_w;
              i_nxt     = n_w >> 1;
              node_nxt  = n_w >> 1;
              xtr_nxt   = 1'b0;
              state_nxt = S_B_RD;
            end else begin
              i_nxt     = IDX_W'(1);
              state_nxt = S_E_RD;
            end
          end
        end
      end

      // Heap build: fetch the record to sift
      S_B_RD: begin
        ram_re    = 1'b1;
        ram_raddr = node_addr;
        state_nxt = S_B_GETV;
      end

      S_B_GETV: begin
        v_nxt     = ram_rdata;
        state_nxt = S_SIFT;
      end

      // Sift step: stop at a leaf, else fetch the left child
      S_SIFT: begin
        if (left_w > size_x) begin
          ram_we    = 1'b1;
          ram_waddr = node_addr;
          ram_wdata = v_r;
          sift_done = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(left_w - 1'b1);
          state_nxt = S_RD_R;
        end
      end

      // Capture the left child, fetch the right one if present
      S_RD_R: begin
        lrec_nxt  = ram_rdata;
        has_r_nxt = (right_w <= size_x);
        if (right_w <= size_x) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(right_w - 1'b1);
        end
        state_nxt = S_CMP;
      end

      // Move the larger child up, or settle the record here
      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = node_addr;
        if (take_r) begin
          ram_wdata = ram_rdata;
          node_nxt  = IDX_W'(right_w);
          state_nxt = S_SIFT;
        end else if (take_l) begin
          ram_wdata = lrec_r;
          node_nxt  = IDX_W'(left_w);
          state_nxt = S_SIFT;
        end else begin
          ram_wdata = v_r;
          sift_done = 1'b1;
        end
      end

      // Extraction: fetch the last heap entry
      S_X_RDI: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(i_r - 1'b1);
        state_nxt = S_X_GETV;
      end

      // Hold it as the record to sift, fetch the root
      S_X_GETV: begin
        v_nxt     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = S_X_WR;
      end

      // Park the root at the end, sift from the root over the shrunk heap
      S_X_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(i_r - 1'b1);
        ram_wdata = ram_rdata;
        node_nxt  = IDX_W'(1);
        size_nxt  = i_r - 1'b1;
        state_nxt = S_SIFT;
      end

      // Emission: fetch entry i
      S_E_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(i_r - 1'b1);
        state_nxt = S_E_LD;
      end

      S_E_LD: begin
        out_key_nxt   = ram_rdata[REC_W-1 -: KEY_W];
        out_tag_nxt   = ram_rdata[TAG_W-1:0];
        out_final_nxt = (i_r == cnt_r);
        out_ovf_nxt   = drop_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_E_WT;
      end

      // Wait for the transfer, then fetch the next entry or end the batch
      S_E_WT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_final_r) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(i_r);
            i_nxt     = i_r + 1'b1;
            state_nxt = S_E_LD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // Advance the outer heapsort loops after each finished sift-down
    if (sift_done) begin
      if (!xtr_r) begin
        if (i_r == IDX_W'(1)) begin
          xtr_nxt   = 1'b1;
          i_nxt     = cnt_r;
          state_nxt = S_X_RDI;
        end else begin
          i_nxt     = i_r - 1'b1;
          node_nxt  = i_r - 1'b1;
          size_nxt  = cnt_r;
          state_nxt = S_B_RD;
        end
      end else begin
        if (i_r == IDX_W'(2)) begin
          i_nxt     = IDX_W'(1);
          state_nxt = S_E_RD;
        end else begin
          i_nxt     = i_r - 1'b1;
          state_nxt = S_X_RDI;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      xtr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      xtr_r       <= xtr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    node_r      <= node_nxt;
    size_r      <= size_nxt;
    v_r         <= v_nxt;
    lrec_r      <= lrec_nxt;
    has_r_r     <= has_r_nxt;
    out_key_r   <= out_key_nxt;
    out_tag_r   <= out_tag_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_sorted_tag = out_tag_r;
  assign out_final_res  = out_final_r;
  assign out_overflow   = out_ovf_r;

endmodule

>>> design/hskr_chk.sv
`include "assert_macros.svh"

module hskr_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [hskr_pkg::KEY_W-1:0] out_sorted_key,
  input logic [hskr_pkg::TAG_W-1:0] out_sorted_tag,
  input logic                       out_final_res,
  input logic                       out_overflow
);

  localparam int PAY_W = hskr_pkg::KEY_W + hskr_pkg::TAG_W + 2;

  logic                       out_xfer;
  logic                       out_held;
  logic [PAY_W-1:0]           out_pay;
  logic                       run_r;
  logic [hskr_pkg::KEY_W-1:0] prev_key_r;
  logic                       prev_ovf_r;

  assign out_xfer = out_valid && !out_stall;
  assign out_held = out_valid && out_stall;
  assign out_pay  = {out_sorted_key, out_sorted_tag, out_final_res, out_overflow};

  // Track the previous result of the current sorted run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (out_xfer) begin
      run_r <= !out_final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_key_r <= out_sorted_key;
      prev_ovf_r <= out_overflow;
    end
  end

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_pay))

  // No record is taken while results of a batch are pending
  `ASSERT_IMPLY(a_in_blocked, clk, rst_n, out_valid, in_stall)

  // Keys come out in ascending order within a run
  `ASSERT_IMPLY(a_ascending, clk, rst_n, out_xfer && run_r, out_sorted_key >= prev_key_r)

  // Overflow flag is the same on every result of a run
  `ASSERT_IMPLY(a_ovf_const, clk, rst_n, out_xfer && run_r, out_overflow == prev_ovf_r)

endmodule

bind heap_sort_keyed_records_core hskr_chk u_hskr_chk (.*);

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int KEY_W          = hskr_pkg::KEY_W;
  localparam int TAG_W          = hskr_pkg::TAG_W;
  localparam int REC_W          = hskr_pkg::REC_W;
  localparam int DEPTH          = hskr_pkg::STORE_SIZE_DEF;
  localparam int RANDOM_ITEMS   = 150;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int SHOW_LIMIT     = 10;

  typedef enum int {KEYS_FULL, KEYS_TIGHT, KEYS_EDGE, KEYS_COARSE} key_mix_t;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSED} stall_mix_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             final_res;
    logic             overflow;
  } sorted_rec_t;

  // Mirror of the batch store; yields the heapsort order of each batch
  class sorted_run_board_t;
    logic [REC_W-1:0] slots [1:DEPTH];
    int unsigned      held;
    bit               dropped;
    sorted_rec_t      sorted_due [$];
    int               flaws;
    int               shown;

    function new();
      held    = 0;
      dropped = 0;
      flaws   = 0;
      shown   = 0;
    endfunction

    // Sift one node down a max-heap; left child wins ties
    function void sift_down(int unsigned node, int unsigned size);
      int unsigned      lc;
      int unsigned      rc;
      int unsigned      best;
      logic [REC_W-1:0] swap;
      bit               settled;
      settled = 0;
      while (!settled) begin
        lc   = 2 * node;
        rc   = lc + 1;
        best = node;
        if (lc <= size && slots[lc][REC_W-1:TAG_W] > slots[node][REC_W-1:TAG_W])
          best = lc;
        if (rc <= size && slots[rc][REC_W-1:TAG_W] > slots[best][REC_W-1:TAG_W])
          best = rc;
        if (best == node) begin
          settled = 1;
        end else begin
          swap        = slots[node];
          slots[node] = slots[best];
          slots[best] = swap;
          node        = best;
        end
      end
    endfunction

    function void heapsort_batch(int unsigned size);
      int               i;
      logic [REC_W-1:0] swap;
      for (i = size / 2; i >= 1; i--)
        sift_down(i, size);
      for (i = size; i >= 2; i--) begin
        swap     = slots[1];
        slots[1] = slots[i];
        slots[i] = swap;
        sift_down(1, i - 1);
      end
    endfunction

    // Store or drop an accepted record; on the last one queue the sorted run
    function void take_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
      sorted_rec_t rec;
      int unsigned k;
      if (held < DEPTH) begin
        held++;
        slots[held] = {key, tag};
      end else begin
        dropped = 1;
      end
      if (last) begin
        heapsort_batch(held);
        for (k = 1; k <= held; k++) begin
          rec.key       = slots[k][REC_W-1:TAG_W];
          rec.tag       = slots[k][TAG_W-1:0];
          rec.final_res = (k == held);
          rec.overflow  = dropped;
          sorted_due.push_back(rec);
        end
        held    = 0;
        dropped = 0;
      end
    endfunction

    function void note_flaw(string msg);
      flaws++;
      if (shown < SHOW_LIMIT) begin
        shown++;
        $display("%0t: %s", $time, msg);
      end
    endfunction

    // Compare one transfer on the result channel with the oldest expectation
    function void match_sorted(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                               logic fin, logic ovf);
      sorted_rec_t want;
      if (sorted_due.size() == 0) begin
        note_flaw($sformatf("unexpected result key=%h tag=%h final=%b overflow=%b",
                            key, tag, fin, ovf));
      end else begin
        want = sorted_due.pop_front();
        if (key !== want.key || tag !== want.tag ||
            fin !== want.final_res || ovf !== want.overflow)
          note_flaw($sformatf({"result mismatch: expected key=%h tag=%h final=%b ",
                               "overflow=%b, got key=%h tag=%h final=%b overflow=%b"},
                              want.key, want.tag, want.final_res, want.overflow,
                              key, tag, fin, ovf));
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [KEY_W-1:0] in_key;
  logic [TAG_W-1:0] in_tag;
  logic             in_last;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KEY_W-1:0] out_sorted_key;
  logic [TAG_W-1:0] out_sorted_tag;
  logic             out_final_res;
  logic             out_overflow;

  sorted_run_board_t sb;
  int                burst_left;
  int                quiet_cycles = 0;
  int                rx_left = 0;
  stall_mix_t        rx_mode = RX_OPEN;

  heap_sort_keyed_records_core #(
    .STORE_SIZE(DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key        (in_key),
    .in_tag        (in_tag),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sorted_key(out_sorted_key),
    .out_sorted_tag(out_sorted_tag),
    .out_final_res (out_final_res),
    .out_overflow  (out_overflow)
  );

  always #6 clk = ~clk;

  function automatic logic [KEY_W-1:0] pick_key(key_mix_t mix);
    logic [KEY_W-1:0] k;
    case (mix)
      KEYS_TIGHT:  k = KEY_W'($urandom_range(0, 3));
      KEYS_EDGE: begin
        case ($urandom_range(0, 3))
          0:       k = '0;
          1:       k = '1;
          2:       k = {1'b1, {(KEY_W-1){1'b0}}};
          default: k = {1'b0, {(KEY_W-1){1'b1}}};
        endcase
      end
      KEYS_COARSE: k = {2'($urandom_range(0, 3)), {(KEY_W-2){1'b0}}};
      default:     k = KEY_W'($urandom);
    endcase
    return k;
  endfunction

  // Keep valid high within a burst; drop it for a random gap between bursts
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      in_key   <= KEY_W'($urandom);
      in_tag   <= TAG_W'($urandom);
      in_last  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Present one record and hold it until the transfer happens
  task automatic send_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
    in_valid <= 1'b1;
    in_key   <= key;
    in_tag   <= tag;
    in_last  <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pace_sender();
  endtask

  task automatic send_batch(int count, key_mix_t mix);
    for (int j = 0; j < count; j++)
      send_record(pick_key(mix), TAG_W'($urandom), j == count - 1);
  endtask

  // Receiver stall: phases of random length, each with its own pattern
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= stall_mix_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(4, 48);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      RX_PULSED: out_stall <= (rx_left[2:0] < 3'd3);
      default:   out_stall <= 1'b0;
    endcase
  end

  // Observe both channels and watch for a stuck run
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.take_record(in_key, in_tag, in_last);
      if (out_valid && !out_stall)
        sb.match_sorted(out_sorted_key, out_sorted_tag, out_final_res, out_overflow);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int items;
    int batches;
    int count;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_key       = '0;
    in_tag       = '0;
    in_last      = 1'b0;
    burst_left   = 0;
    sb           = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-record batches at both key and tag extremes
    send_record('0, '0, 1'b1);
    send_record('1, '1, 1'b1);
    // Two records arriving out of order
    send_record(16'h0001, 16'hAAAA, 1'b0);
    send_record(16'h0000, 16'h5555, 1'b1);
    // Mixed extremes with repeated keys
    send_record(16'hFFFF, 16'h0001, 1'b0);
    send_record(16'h0000, 16'h0002, 1'b0);
    send_record(16'hFFFF, 16'h0003, 1'b0);
    send_record(16'h0000, 16'h0004, 1'b0);
    send_record(16'h8000, 16'h0005, 1'b0);
    send_record(16'h7FFF, 16'h0006, 1'b1);
    // All keys equal: tag order follows the heap's tie rule
    for (int t = 0; t < 7; t++)
      send_record(16'h0005, TAG_W'(t), t == 6);
    // Interleaved ties of two keys
    for (int t = 0; t < 6; t++)
      send_record((t == 2 || t == 4) ? 16'h0001 : 16'h0003, TAG_W'(16'h0100 + t), t == 5);

    // Random batches; one fills the store exactly, one overruns it
    items   = 0;
    batches = 0;
    while (items < RANDOM_ITEMS) begin
      if (batches == 1)
        count = DEPTH;
      else if (batches == 3)
        count = DEPTH + $urandom_range(1, 4);
      else
        count = $urandom_range(1, 12);
      send_batch(count, key_mix_t'($urandom_range(0, 3)));
      items += count;
      batches++;
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain the last sorted run, then watch for stray results
    while (sb.sorted_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.flaws == 0 && sb.sorted_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/hskr_pkg.sv
design/hskr_ram.sv
design/heap_sort_keyed_records_core.sv
design/hskr_chk.sv
bench/tb.sv
